>>> src/i2c_bit_level_master_top_defines.svh
// Assertion macros for the I2C bit-level master.
// Included by the modules that carry concurrent checks; needs a clk and rst in scope.
`ifndef I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define I2CBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define I2CBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/i2cbm_pkg.sv
// Shared types and codes for the I2C bit-level master.
// Used by i2c_bit_level_master_top; depends on nothing.
`timescale 1ns / 1ps

package i2cbm_pkg;

  // Command codes carried in the operation field
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_ACK   = 3'd5;
  localparam logic [2:0] OP_NACK  = 3'd6;
  localparam logic [2:0] OP_RACK  = 3'd7;

  // Steps per command
  localparam logic [4:0] STEPS_SHORT = 5'd3;
  localparam logic [4:0] STEPS_BYTE  = 5'd18;

  localparam logic [7:0] RESET_DELAY = 8'd10;

  // Register map
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_DELAY_TICKS = 3'd0;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_bit;
  } out_item_t;

endpackage

>>> src/i2c_bit_level_master_top.sv
// I2C bit-level master: command sequencer with APB delay register.
// Depends on i2cbm_pkg and i2c_bit_level_master_top_defines.svh.
`timescale 1ns / 1ps
`include "i2c_bit_level_master_top_defines.svh"

// Each input transfer is one tick of the bus sequencer and yields exactly one output
// transfer carrying the SCL/SDA drive levels, busy, done, the last read byte and the
// last received ACK bit. The sequencer state is updated once per accepted tick, and
// the result sits in an output register, so a new tick is taken every clock cycle as
// long as the output side keeps taking results (in_ready is high whenever the output
// register is empty or being emptied). Commands (start, stop, write byte, read byte,
// ack, nack, receive ack) are only taken while idle; each step of a command holds its
// pin levels for delay_ticks ticks (0 acts as 1), set through the APB register at 0x0.
module i2c_bit_level_master_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  i2cbm_pkg::in_item_t          in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output i2cbm_pkg::out_item_t         out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2cbm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import i2cbm_pkg::*;

  // Registers
  logic [7:0] delay_ticks;
  logic [2:0] current_command;
  logic [4:0] sequence_step;
  logic [7:0] delay_count;
  logic [7:0] shift_register;
  logic       scl_level;
  logic       sda_level;
  logic       ack_register;
  logic [7:0] held_read;

  logic [2:0] current_command_next;
  logic [4:0] sequence_step_next;
  logic [7:0] delay_count_next;
  logic [7:0] shift_register_next;
  logic       scl_level_next;
  logic       sda_level_next;
  logic       ack_register_next;
  logic [7:0] held_read_next;
  logic       done_next;

  logic       in_fire;
  logic [7:0] hold_length;
  logic [4:0] step_inc;
  logic [4:0] step_total;
  logic       delay_sel;

  // Pin levels set on entering step s of command cmd
  function automatic logic [1:0] step_levels(input logic [2:0] cmd, input logic [4:0] s,
                                             input logic [7:0] shreg, input logic scl,
                                             input logic sda);
    logic scl_v;
    logic sda_v;
    scl_v = scl;
    sda_v = sda;
    case (cmd)
      OP_START: begin
        if (s == 5'd0) begin
          scl_v = 1'b1;
          sda_v = 1'b1;
        end else if (s == 5'd1) begin
          sda_v = 1'b0;
        end else begin
          scl_v = 1'b0;
        end
      end
      OP_STOP: begin
        if (s == 5'd0) begin
          scl_v = 1'b0;
          sda_v = 1'b0;
        end else if (s == 5'd1) begin
          scl_v = 1'b1;
        end else begin
          sda_v = 1'b1;
        end
      end
      OP_WRITE: begin
        if (s < 5'd16) begin
          if (!s[0]) begin
            scl_v = 1'b0;
            sda_v = shreg[3'd7 - s[3:1]];
          end else begin
            scl_v = 1'b1;
          end
        end else if (s == 5'd16) begin
          scl_v = 1'b0;
        end else begin
          sda_v = 1'b1;
        end
      end
      OP_READ: begin
        if (s == 5'd0) begin
          sda_v = 1'b1;
        end else if (s < 5'd17) begin
          scl_v = ~s[0];
        end else begin
          scl_v = 1'b0;
        end
      end
      OP_ACK, OP_NACK: begin
        if (s == 5'd0) begin
          scl_v = 1'b0;
          sda_v = (cmd == OP_NACK);
        end else if (s == 5'd1) begin
          scl_v = 1'b1;
        end else begin
          scl_v = 1'b0;
        end
      end
      OP_RACK: begin
        if (s == 5'd0) begin
          sda_v = 1'b1;
        end else if (s == 5'd1) begin
          scl_v = 1'b1;
        end else begin
          scl_v = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return {scl_v, sda_v};
  endfunction

  assign in_ready    = !out_valid || out_ready;
  assign in_fire     = in_valid && in_ready;
  assign hold_length = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;
  assign step_inc    = sequence_step + 5'd1;
  assign step_total  = (current_command == OP_WRITE || current_command == OP_READ) ?
                       STEPS_BYTE : STEPS_SHORT;

  always_comb begin
    current_command_next = current_command;
    sequence_step_next   = sequence_step;
    delay_count_next     = delay_count;
    shift_register_next  = shift_register;
    scl_level_next       = scl_level;
    sda_level_next       = sda_level;
    ack_register_next    = ack_register;
    held_read_next       = held_read;
    done_next            = 1'b0;
    if (current_command == OP_NONE) begin
      if (in_item.operation != OP_NONE) begin
        current_command_next = in_item.operation;
        sequence_step_next   = 5'd0;
        shift_register_next  = (in_item.operation == OP_WRITE) ? in_item.write_data : 8'd0;
        {scl_level_next, sda_level_next} = step_levels(in_item.operation, 5'd0,
                                                       shift_register_next, scl_level,
                                                       sda_level);
        delay_count_next     = hold_length;
      end
    end else if (delay_count > 8'd1) begin
      delay_count_next = delay_count - 8'd1;
    end else begin
      // Sample SDA at the end of an SCL high step
      if (current_command == OP_READ && sequence_step >= 5'd2 && sequence_step <= 5'd16 &&
          !sequence_step[0]) begin
        shift_register_next = {shift_register[6:0], in_item.sda_in};
      end
      if (current_command == OP_RACK && sequence_step == 5'd1) begin
        ack_register_next = in_item.sda_in;
      end
      if (step_inc >= step_total) begin
        if (current_command == OP_READ) begin
          held_read_next = shift_register_next;
        end
        current_command_next = OP_NONE;
        sequence_step_next   = 5'd0;
        delay_count_next     = 8'd0;
        done_next            = 1'b1;
      end else begin
        sequence_step_next = step_inc;
        {scl_level_next, sda_level_next} = step_levels(current_command, step_inc,
                                                       shift_register_next, scl_level,
                                                       sda_level);
        delay_count_next   = hold_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_command <= OP_NONE;
      sequence_step   <= 5'd0;
      delay_count     <= 8'd0;
      shift_register  <= 8'd0;
      scl_level       <= 1'b1;
      sda_level       <= 1'b1;
      ack_register    <= 1'b1;
      held_read       <= 8'd0;
      out_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        current_command <= current_command_next;
        sequence_step   <= sequence_step_next;
        delay_count     <= delay_count_next;
        shift_register  <= shift_register_next;
        scl_level       <= scl_level_next;
        sda_level       <= sda_level_next;
        ack_register    <= ack_register_next;
        held_read       <= held_read_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: load on every accepted tick
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_item.scl_out   <= scl_level_next;
      out_item.sda_out   <= sda_level_next;
      out_item.busy_res  <= (current_command_next != OP_NONE);
      out_item.done_res  <= done_next;
      out_item.read_byte <= held_read_next;
      out_item.ack_bit   <= ack_register_next;
    end
  end

  // APB delay register, decoded on the word address
  assign pready    = 1'b1;
  assign delay_sel = (paddr[ADDR_W-1:2] == ADDR_DELAY_TICKS[ADDR_W-1:2]);
  assign prdata    = delay_sel ? {24'd0, delay_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= RESET_DELAY;
    end else if (psel && penable && pwrite && pready && delay_sel) begin
      delay_ticks <= pwdata[7:0];
    end
  end

  `I2CBM_ASSERT(a_busy_has_hold, (current_command != OP_NONE) |-> (delay_count != 8'd0), "running command without a hold count")
  `I2CBM_ASSERT(a_idle_clean, (current_command == OP_NONE) |-> (sequence_step == 5'd0 && delay_count == 8'd0), "idle sequencer holds a stale step or count")
  `I2CBM_ASSERT(a_cmd_starts, (in_fire && current_command == OP_NONE && in_item.operation != OP_NONE) |=> (current_command != OP_NONE && out_item.busy_res), "accepted command did not start")
  `I2CBM_ASSERT_ALWAYS(a_done_not_busy, (out_valid && out_item.done_res) |-> !out_item.busy_res, "done reported while still busy")

endmodule

>>> dv/i2cbm_checker.sv
// Checker for the I2C bit-level master: mirrors the command sequencer per tick.
// Watches the tick, result and APB channels; depends on i2cbm_pkg only.
`timescale 1ns / 1ps

module i2cbm_checker
  import i2cbm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  in_item_t            in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  out_item_t           out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending,
  output int                  compared
);

  // Sequencer mirror
  logic [7:0] tick_delay;
  logic [2:0] bus_cmd;
  logic [4:0] step_no;
  logic [7:0] hold_left;
  logic [7:0] shreg;
  logic       scl_q;
  logic       sda_q;
  logic       ack_q;
  logic [7:0] read_hold;

  out_item_t pin_results_q[$];
  int        mismatches = 0;
  int        matched = 0;

  assign fail_count = mismatches;
  assign compared   = matched;

  function automatic logic [7:0] hold_ticks();
    return (tick_delay == 8'd0) ? 8'd1 : tick_delay;
  endfunction

  // Set the pin levels of the current step
  function automatic void drive_step();
    case (bus_cmd)
      OP_START: begin
        if (step_no == 5'd0) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
        end else if (step_no == 5'd1) begin
          sda_q = 1'b0;
        end else begin
          scl_q = 1'b0;
        end
      end
      OP_STOP: begin
        if (step_no == 5'd0) begin
          scl_q = 1'b0;
          sda_q = 1'b0;
        end else if (step_no == 5'd1) begin
          scl_q = 1'b1;
        end else begin
          sda_q = 1'b1;
        end
      end
      OP_WRITE: begin
        if (step_no < 5'd16) begin
          if (!step_no[0]) begin
            scl_q = 1'b0;
            sda_q = shreg[3'd7 - step_no[3:1]];
          end else begin
            scl_q = 1'b1;
          end
        end else if (step_no == 5'd16) begin
          scl_q = 1'b0;
        end else begin
          sda_q = 1'b1;
        end
      end
      OP_READ: begin
        if (step_no == 5'd0) begin
          sda_q = 1'b1;
        end else if (step_no < 5'd17) begin
          scl_q = ~step_no[0];
        end else begin
          scl_q = 1'b0;
        end
      end
      OP_ACK, OP_NACK: begin
        if (step_no == 5'd0) begin
          scl_q = 1'b0;
          sda_q = (bus_cmd == OP_NACK);
        end else if (step_no == 5'd1) begin
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      OP_RACK: begin
        if (step_no == 5'd0) begin
          sda_q = 1'b1;
        end else if (step_no == 5'd1) begin
          scl_q = 1'b1;
        end else begin
          scl_q = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the mirror by one tick and return the pin levels it should show
  function automatic out_item_t predict_tick(in_item_t tick);
    logic       done;
    logic [4:0] nxt;
    logic [4:0] total;
    done = 1'b0;
    if (bus_cmd == OP_NONE) begin
      if (tick.operation != OP_NONE) begin
        bus_cmd = tick.operation;
        step_no = 5'd0;
        shreg   = (tick.operation == OP_WRITE) ? tick.write_data : 8'd0;
        drive_step();
        hold_left = hold_ticks();
      end
    end else if (hold_left > 8'd1) begin
      hold_left = hold_left - 8'd1;
    end else begin
      // sample SDA at the end of each SCL high step
      if (bus_cmd == OP_READ && step_no >= 5'd2 && step_no <= 5'd16 && !step_no[0])
        shreg = {shreg[6:0], tick.sda_in};
      if (bus_cmd == OP_RACK && step_no == 5'd1)
        ack_q = tick.sda_in;
      nxt   = step_no + 5'd1;
      total = (bus_cmd == OP_WRITE || bus_cmd == OP_READ) ? STEPS_BYTE : STEPS_SHORT;
      if (nxt >= total) begin
        if (bus_cmd == OP_READ)
          read_hold = shreg;
        bus_cmd   = OP_NONE;
        step_no   = 5'd0;
        hold_left = 8'd0;
        done      = 1'b1;
      end else begin
        step_no = nxt;
        drive_step();
        hold_left = hold_ticks();
      end
    end
    return '{scl_out: scl_q, sda_out: sda_q, busy_res: (bus_cmd != OP_NONE),
             done_res: done, read_byte: read_hold, ack_bit: ack_q};
  endfunction

  function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      tick_delay = RESET_DELAY;
      bus_cmd    = OP_NONE;
      step_no    = 5'd0;
      hold_left  = 8'd0;
      shreg      = 8'd0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      ack_q      = 1'b1;
      read_hold  = 8'd0;
      pin_results_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pin_results_q.size() == 0) begin
          mismatches++;
          $error("result transfer with no expected result waiting");
        end else begin
          want = pin_results_q.pop_front();
          check_field("scl_out", {7'd0, want.scl_out}, {7'd0, out_item.scl_out});
          check_field("sda_out", {7'd0, want.sda_out}, {7'd0, out_item.sda_out});
          check_field("busy_res", {7'd0, want.busy_res}, {7'd0, out_item.busy_res});
          check_field("done_res", {7'd0, want.done_res}, {7'd0, out_item.done_res});
          check_field("read_byte", want.read_byte, out_item.read_byte);
          check_field("ack_bit", {7'd0, want.ack_bit}, {7'd0, out_item.ack_bit});
          matched++;
        end
      end
      if (in_valid && in_ready)
        pin_results_q.push_back(predict_tick(in_item));
      if (psel && penable && pready &&
          paddr[ADDR_W-1:2] == ADDR_DELAY_TICKS[ADDR_W-1:2]) begin
        if (pwrite)
          tick_delay = pwdata[7:0];
        else
          check_field("prdata", tick_delay, prdata[7:0]);
      end
    end
    pending <= pin_results_q.size();
  end

endmodule

>>> dv/tb_i2c_bit_level_master_top.sv
// Top of the I2C bit-level master testbench: clock, reset, tick and APB stimulus.
// Depends on i2cbm_pkg, i2c_bit_level_master_top and i2cbm_checker.
`timescale 1ns / 1ps

module tb_i2c_bit_level_master_top;
  import i2cbm_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int         fail_count;
  int         pending;
  int         compared;
  int         send_idle_pct = 31;
  int         recv_idle_pct = 54;
  logic [7:0] cur_delay = RESET_DELAY;
  int         cmd_count = 0;
  int         tick_count = 0;

  i2c_bit_level_master_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2cbm_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .fail_count(fail_count), .pending(pending), .compared(compared)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_tick(input logic [2:0] op, input logic [7:0] wd, input logic sda);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{operation: op, write_data: wd, sda_in: sda};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tick_count++;
  endtask

  function automatic logic pick_sda(input int sda_mode);
    return (sda_mode < 2) ? sda_mode[0] : 1'($urandom);
  endfunction

  // Issue one command from idle, then tick through its whole sequence.
  // Commands sent meanwhile are ignored; the done tick always carries one.
  task automatic run_cmd(input logic [2:0] op, input logic [7:0] wd, input int sda_mode);
    int span;
    int k;
    logic [2:0] noise;
    span = (op == OP_WRITE || op == OP_READ) ? STEPS_BYTE : STEPS_SHORT;
    span = span * ((cur_delay == 8'd0) ? 1 : cur_delay);
    send_tick(op, wd, pick_sda(sda_mode));
    cmd_count++;
    for (k = 1; k <= span; k++) begin
      noise = (k == span || $urandom_range(1)) ? 3'($urandom_range(7, 1)) : OP_NONE;
      send_tick(noise, 8'($urandom), pick_sda(sda_mode));
    end
    repeat ($urandom_range(2)) send_tick(OP_NONE, 8'($urandom), 1'($urandom));
  endtask

  // Start, address, then a few data bytes in one direction, then stop
  task automatic run_transfer();
    int n;
    int k;
    bit rd;
    n  = $urandom_range(3, 1);
    rd = 1'($urandom_range(1));
    run_cmd(OP_START, 8'($urandom), 2);
    run_cmd(OP_WRITE, {7'($urandom), rd}, 2);
    run_cmd(OP_RACK, 8'($urandom), 2);
    for (k = 1; k <= n; k++) begin
      if (rd) begin
        run_cmd(OP_READ, 8'($urandom), 2);
        run_cmd((k == n) ? OP_NACK : OP_ACK, 8'($urandom), 2);
      end else begin
        run_cmd(OP_WRITE, 8'($urandom), 2);
        run_cmd(OP_RACK, 8'($urandom), 2);
      end
    end
    run_cmd(OP_STOP, 8'($urandom), 2);
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off until every tick sent so far has its result back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] dly, input int snd, input int rcv,
                           input int n_cmds);
    int stop_at;
    drain();
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    apb_access(1'b1, ADDR_DELAY_TICKS, {24'($urandom), dly});
    apb_access(1'b0, ADDR_DELAY_TICKS, '0);
    cur_delay = dly;
    stop_at = cmd_count + n_cmds;
    while (cmd_count < stop_at) begin
      if ($urandom_range(9) < 8)
        run_transfer();
      else
        run_cmd(3'($urandom_range(7, 1)), 8'($urandom), 2);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass: a short sequence at the reset delay, then every command at delay 1
    send_tick(OP_NONE, 8'hFF, 1'b0);
    send_tick(OP_NONE, 8'h00, 1'b1);
    run_cmd(OP_START, 8'h00, 2);
    run_cmd(OP_STOP, 8'h00, 2);
    run_phase(8'd1, 31, 54, 0);
    run_cmd(OP_START, 8'h00, 2);
    run_cmd(OP_WRITE, 8'h00, 2);
    run_cmd(OP_RACK, 8'h00, 0);
    run_cmd(OP_WRITE, 8'hFF, 2);
    run_cmd(OP_RACK, 8'hFF, 1);
    run_cmd(OP_WRITE, 8'hA5, 2);
    run_cmd(OP_READ, 8'h00, 1);
    run_cmd(OP_ACK, 8'h00, 2);
    run_cmd(OP_READ, 8'hFF, 0);
    run_cmd(OP_NACK, 8'h00, 2);
    run_cmd(OP_READ, 8'h5A, 2);
    run_cmd(OP_RACK, 8'h00, 2);
    run_cmd(OP_STOP, 8'h00, 2);
    run_cmd(OP_STOP, 8'hFF, 2);
    run_cmd(OP_READ, 8'h00, 2);
    run_cmd(OP_WRITE, 8'h3C, 2);

    // Random traffic over the delay range and the three handshake mixes
    run_phase(8'd1, 31, 54, 30);
    run_phase(8'd0, 31, 54, 20);
    drain();
    apb_access(1'b1, ADDR_UNMAPPED, 32'($urandom));
    apb_access(1'b0, ADDR_DELAY_TICKS, '0);
    run_phase(8'd3, 54, 31, 12);
    run_phase(8'd2, 0, 0, 12);
    run_phase(8'd1, 0, 0, 15);
    drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d bus commands over %0d ticks at delays 10, 1, 0, 3, 2, 1,",
             cmd_count, tick_count);
    $display("with %0d tick results compared against the sequencer mirror", compared);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
